// File: rtl/sgr_pkg.sv
// Shared types and constants for the storage growth rate estimator.
package sgr_pkg;

  localparam int MSD_W = 27;
  localparam logic [MSD_W-1:0] MS_PER_DAY = 27'd86400000;

  localparam int RATE_BITS      = 56;
  localparam int RATE_OUT_BITS  = 48;
  localparam int DAYS_BITS      = 54;
  localparam int COUNT_BITS     = 8;
  localparam int MIN_ELAPSED_MS = 1000;
  localparam int MIN_SAMPLES    = 2;
  localparam int EWMA_DIVISOR   = 5;
  // 4 * rate + sample
  localparam int EWMA_W         = RATE_BITS + 3;

  localparam int OUT_W   = RATE_OUT_BITS + DAYS_BITS + COUNT_BITS;
  localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_DIV_SAMPLE,
    ST_WAIT_SAMPLE,
    ST_EWMA,
    ST_WAIT_EWMA,
    ST_DAYS,
    ST_WAIT_DAYS,
    ST_OUT
  } sgr_state_t;

  typedef enum logic [1:0] {
    DIV_SAMPLE,
    DIV_EWMA,
    DIV_DAYS
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     decide;
    logic     check;
    logic     mul_lo;
    logic     mul_hi;
    logic     add_num;
    logic     div_start;
    div_sel_t div_sel;
    logic     latch_sample;
    logic     rate_from_sample;
    logic     rate_from_div;
    logic     bump_count;
    logic     days_unknown;
    logic     days_zero;
    logic     days_from_div;
    logic     load_out;
  } sgr_cmd_t;

  typedef struct packed {
    logic is_cleanup;
    logic sample_ok;
    logic first_sample;
    logic div_done;
    logic days_known;
    logic free_above;
    logic out_free;
  } sgr_status_t;

endpackage

// File: rtl/sgr_div.sv
// Serial restoring divider, one quotient bit per cycle.
module sgr_div #(
  parameter int NW = 79,
  parameter int DW = 56
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [NW-1:0]               num,
  input  logic [DW-1:0]               den,
  input  logic [$clog2(NW+1)-1:0]     nbits,
  output logic                        done,
  output logic [NW-1:0]               quot
);

  localparam int CW = $clog2(NW + 1);
  localparam int IW = $clog2(NW);

  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_m1;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  // only the low nbits of the numerator are walked, the rest are zero
  assign cnt_m1 = cnt - CW'(1);
  assign trial  = {rem, num_q[cnt_m1[IW-1:0]]};
  assign fits   = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nbits;
      end else if (busy) begin
        cnt <= cnt_m1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_q <= num;
      den_q <= den;
      rem   <= '0;
      quot  <= '0;
    end else if (busy) begin
      rem  <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      quot <= {quot[NW-2:0], fits};
    end
  end

endmodule

// File: rtl/sgr_datapath.sv
// Datapath: estimator state, multiply, shared divider and result register.
module sgr_datapath #(
  parameter int BYTE_BITS      = 44,
  parameter int TIME_BITS      = 48,
  parameter int RATE_FRAC_BITS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  sgr_pkg::sgr_cmd_t                           ctl,
  output sgr_pkg::sgr_status_t                        sts,
  input  logic [((3*BYTE_BITS+TIME_BITS+7)/8)*8-1:0]  s_tdata,
  input  logic                                        s_tuser,
  input  logic                                        cfg_wr,
  input  logic [BYTE_BITS-1:0]                        cfg_data,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  output logic [sgr_pkg::OUT_PAD-1:0]                 m_tdata,
  output logic                                        m_tuser
);
  import sgr_pkg::*;

  localparam int PROD_W = BYTE_BITS + MSD_W;
  localparam int SNUM_W = PROD_W + RATE_FRAC_BITS;
  localparam int DNUM_W = BYTE_BITS + RATE_FRAC_BITS;
  localparam int NW     = (SNUM_W > DNUM_W) ? SNUM_W : DNUM_W;
  localparam int DW     = (TIME_BITS > RATE_BITS) ? TIME_BITS : RATE_BITS;
  localparam int CW     = $clog2(NW + 1);
  localparam int LO_W   = BYTE_BITS / 2;
  localparam int HI_W   = BYTE_BITS - LO_W;
  localparam logic [RATE_BITS:0] HALF = (RATE_BITS+1)'((2 ** RATE_FRAC_BITS) / 2);

  // divide by five, one byte digit a cycle
  localparam int Q5_W     = ((EWMA_W + 7) / 8) * 8;
  localparam int Q5_STEPS = Q5_W / 8;
  localparam int Q5_CW    = $clog2(Q5_STEPS + 1);
  // floor(v / 5) == (v * 3277) >> 14 for every v below 5 * 256
  localparam logic [21:0] RECIP_5 = 22'd3277;

  // latched request
  logic                 is_clean;
  logic [BYTE_BITS-1:0] used;
  logic [TIME_BITS-1:0] tnow;
  logic [BYTE_BITS-1:0] recl;
  logic [BYTE_BITS-1:0] freeb;

  // estimator state
  logic [BYTE_BITS-1:0]  prev_used;
  logic [TIME_BITS-1:0]  prev_time;
  logic [BYTE_BITS-1:0]  pending;
  logic [RATE_BITS-1:0]  rate;
  logic [COUNT_BITS-1:0] count;
  logic [BYTE_BITS-1:0]  reserve;
  logic                  taken;

  // working registers
  logic [BYTE_BITS-1:0]  base;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  time_ok;
  logic [BYTE_BITS-1:0]  delta;
  logic [LO_W+MSD_W-1:0] prod_lo;
  logic [HI_W+MSD_W-1:0] prod_hi;
  logic [SNUM_W-1:0]     num_reg;
  logic [RATE_BITS-1:0]  sample;
  logic [DAYS_BITS-1:0]  days;

  // result register
  logic [RATE_OUT_BITS-1:0] out_rate;
  logic [DAYS_BITS-1:0]     out_days;
  logic [COUNT_BITS-1:0]    out_count;
  logic                     out_taken;

  logic [BYTE_BITS:0]     clean_sum;
  logic [PROD_W-1:0]      prod_sum;
  logic [EWMA_W-1:0]      ewma_num;
  logic [DNUM_W-1:0]      days_num;
  logic [RATE_BITS:0]     rate_round;
  logic [RATE_BITS:0]     rate_shift;
  logic [RATE_OUT_BITS-1:0] rate_out;
  logic [NW-1:0]          div_num;
  logic [DW-1:0]          div_den;
  logic [CW-1:0]          div_nbits;
  logic                   div_go;
  logic                   div_done;
  logic [NW-1:0]          quot;

  logic [Q5_W-1:0]  q5_num;
  logic [Q5_W-1:0]  q5_quot;
  logic [2:0]       q5_rem;
  logic [Q5_CW-1:0] q5_cnt;
  logic             q5_start;
  logic             q5_busy;
  logic             q5_done;
  logic [10:0]      q5_v;
  logic [21:0]      q5_prod;
  logic [7:0]       q5_digit;

  assign clean_sum  = {1'b0, pending} + {1'b0, recl};
  assign prod_sum   = PROD_W'(prod_lo) + (PROD_W'(prod_hi) << LO_W);
  assign ewma_num   = EWMA_W'({rate, 2'b00}) + EWMA_W'(sample);
  assign days_num   = DNUM_W'(freeb - reserve) << RATE_FRAC_BITS;
  assign rate_round = {1'b0, rate} + HALF;
  assign rate_shift = rate_round >> RATE_FRAC_BITS;
  assign rate_out   = (|rate_shift[RATE_BITS:RATE_OUT_BITS]) ? '1
                                                             : rate_shift[RATE_OUT_BITS-1:0];

  always_comb begin
    unique case (ctl.div_sel)
      DIV_SAMPLE: begin
        div_num   = NW'(num_reg);
        div_den   = DW'(elapsed);
        div_nbits = CW'(SNUM_W);
      end
      DIV_DAYS: begin
        div_num   = NW'(days_num);
        div_den   = DW'(rate);
        div_nbits = CW'(DNUM_W);
      end
      default: begin
        div_num   = '0;
        div_den   = DW'(1);
        div_nbits = CW'(1);
      end
    endcase
  end

  assign div_go   = ctl.div_start && (ctl.div_sel != DIV_EWMA);
  assign q5_start = ctl.div_start && (ctl.div_sel == DIV_EWMA);

  sgr_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .nbits (div_nbits),
    .done  (div_done),
    .quot  (quot)
  );

  // long division by five: remainder below five, so each digit fits a byte
  assign q5_v     = {q5_rem, q5_num[Q5_W-1 -: 8]};
  assign q5_prod  = 22'(q5_v) * RECIP_5;
  assign q5_digit = q5_prod[21:14];

  always_ff @(posedge clk) begin
    if (rst) begin
      q5_busy <= 1'b0;
      q5_done <= 1'b0;
      q5_cnt  <= '0;
    end else begin
      q5_done <= 1'b0;
      if (q5_start) begin
        q5_busy <= 1'b1;
        q5_cnt  <= Q5_CW'(Q5_STEPS);
      end else if (q5_busy) begin
        q5_cnt <= q5_cnt - Q5_CW'(1);
        if (q5_cnt == Q5_CW'(1)) begin
          q5_busy <= 1'b0;
          q5_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q5_start) begin
      q5_num  <= Q5_W'(ewma_num);
      q5_rem  <= '0;
      q5_quot <= '0;
    end else if (q5_busy) begin
      q5_num  <= {q5_num[Q5_W-9:0], 8'd0};
      q5_rem  <= 3'(q5_v - 11'(q5_digit) * 11'(EWMA_DIVISOR));
      q5_quot <= {q5_quot[Q5_W-9:0], q5_digit};
    end
  end

  always_comb begin
    sts.is_cleanup   = is_clean;
    sts.sample_ok    = time_ok && (elapsed >= TIME_BITS'(MIN_ELAPSED_MS)) && (used >= base);
    sts.first_sample = count == '0;
    sts.div_done     = div_done || q5_done;
    sts.days_known   = (count >= COUNT_BITS'(MIN_SAMPLES)) && (rate != '0);
    sts.free_above   = freeb > reserve;
    sts.out_free     = !m_tvalid || m_tready;
  end

  // estimator state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_used <= '0;
      prev_time <= '0;
      pending   <= '0;
      rate      <= '0;
      count     <= '0;
      reserve   <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        reserve <= cfg_data;
      end
      if (ctl.decide) begin
        if (is_clean) begin
          pending <= clean_sum[BYTE_BITS] ? '1 : clean_sum[BYTE_BITS-1:0];
        end else begin
          prev_used <= used;
          prev_time <= tnow;
          pending   <= '0;
        end
      end
      if (ctl.rate_from_sample) begin
        rate <= sample;
      end else if (ctl.rate_from_div) begin
        rate <= q5_quot[RATE_BITS-1:0];
      end
      if (ctl.bump_count && count != '1) begin
        count <= count + COUNT_BITS'(1);
      end
      if (ctl.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      is_clean <= s_tuser;
      used     <= s_tdata[BYTE_BITS-1:0];
      tnow     <= s_tdata[BYTE_BITS +: TIME_BITS];
      recl     <= s_tdata[BYTE_BITS+TIME_BITS +: BYTE_BITS];
      freeb    <= s_tdata[2*BYTE_BITS+TIME_BITS +: BYTE_BITS];
      taken    <= 1'b0;
    end else if (ctl.bump_count) begin
      taken <= 1'b1;
    end
    if (ctl.decide) begin
      // base is the previous usage less the cleanup credit, floored at zero
      base    <= (prev_used > pending) ? prev_used - pending : '0;
      elapsed <= tnow - prev_time;
      time_ok <= (prev_time != '0) && (tnow > prev_time);
    end
    if (ctl.check) begin
      delta <= used - base;
    end
    if (ctl.mul_lo) begin
      prod_lo <= (LO_W+MSD_W)'(delta[LO_W-1:0]) * (LO_W+MSD_W)'(MS_PER_DAY);
    end
    if (ctl.mul_hi) begin
      prod_hi <= (HI_W+MSD_W)'(delta[BYTE_BITS-1:LO_W]) * (HI_W+MSD_W)'(MS_PER_DAY);
    end
    if (ctl.add_num) begin
      num_reg <= SNUM_W'(prod_sum) << RATE_FRAC_BITS;
    end
    if (ctl.latch_sample) begin
      sample <= (|quot[NW-1:RATE_BITS]) ? '1 : quot[RATE_BITS-1:0];
    end
    if (ctl.days_unknown) begin
      days <= '1;
    end else if (ctl.days_zero) begin
      days <= '0;
    end else if (ctl.days_from_div) begin
      days <= (|quot[NW-1:DAYS_BITS-1]) ? {1'b0, {(DAYS_BITS-1){1'b1}}}
                                        : {1'b0, quot[DAYS_BITS-2:0]};
    end
    if (ctl.load_out) begin
      out_rate  <= rate_out;
      out_days  <= days;
      out_count <= count;
      out_taken <= taken;
    end
  end

  assign m_tdata = {{(OUT_PAD-OUT_W){1'b0}}, out_count, out_days, out_rate};
  assign m_tuser = out_taken;

endmodule

// File: rtl/sgr_ctrl.sv
// Controller: sequences one request through decide, sample, update and days steps.
module sgr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  sgr_pkg::sgr_status_t sts,
  output sgr_pkg::sgr_cmd_t    ctl
);
  import sgr_pkg::*;

  sgr_state_t state;
  sgr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctl         = '0;
    ctl.div_sel = DIV_SAMPLE;
    s_tready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ctl.decide = 1'b1;
        state_next = sts.is_cleanup ? ST_DAYS : ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.sample_ok) begin
          ctl.check  = 1'b1;
          state_next = ST_MUL_LO;
        end else begin
          state_next = ST_DAYS;
        end
      end
      ST_MUL_LO: begin
        ctl.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        ctl.mul_hi = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        ctl.add_num = 1'b1;
        state_next  = ST_DIV_SAMPLE;
      end
      ST_DIV_SAMPLE: begin
        ctl.div_start = 1'b1;
        ctl.div_sel   = DIV_SAMPLE;
        state_next    = ST_WAIT_SAMPLE;
      end
      ST_WAIT_SAMPLE: begin
        if (sts.div_done) begin
          ctl.latch_sample = 1'b1;
          state_next       = ST_EWMA;
        end
      end
      ST_EWMA: begin
        ctl.bump_count = 1'b1;
        if (sts.first_sample) begin
          ctl.rate_from_sample = 1'b1;
          state_next           = ST_DAYS;
        end else begin
          ctl.div_start = 1'b1;
          ctl.div_sel   = DIV_EWMA;
          state_next    = ST_WAIT_EWMA;
        end
      end
      ST_WAIT_EWMA: begin
        ctl.div_sel = DIV_EWMA;
        if (sts.div_done) begin
          ctl.rate_from_div = 1'b1;
          state_next        = ST_DAYS;
        end
      end
      ST_DAYS: begin
        if (!sts.days_known) begin
          ctl.days_unknown = 1'b1;
          state_next       = ST_OUT;
        end else if (!sts.free_above) begin
          ctl.days_zero = 1'b1;
          state_next    = ST_OUT;
        end else begin
          ctl.div_start = 1'b1;
          ctl.div_sel   = DIV_DAYS;
          state_next    = ST_WAIT_DAYS;
        end
      end
      ST_WAIT_DAYS: begin
        ctl.div_sel = DIV_DAYS;
        if (sts.div_done) begin
          ctl.days_from_div = 1'b1;
          state_next        = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait here only while an earlier result is still unread
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/storage_growth_rate_estimator.sv
// Storage growth rate estimator: top level joining controller and datapath.
// A cleanup request goes from decide straight to the days step; an observation with a valid
// sample adds a split multiply, a serial division and the rate update. A days estimate
// adds a further serial division on the divider that the sample step uses.
// One request at a time: the next is taken from the cycle the result turns valid on.
// Synchronous reset clears rate, count, previous sample, cleanup sum and reserve.
module storage_growth_rate_estimator #(
  parameter int BYTE_BITS      = 44,
  parameter int TIME_BITS      = 48,
  parameter int RATE_FRAC_BITS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // usage, time in ms, reclaimed, free space
  input  logic [((3*BYTE_BITS+TIME_BITS+7)/8)*8-1:0]  s_tdata,
  // cmd
  input  logic                                        s_tuser,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // rate_per_day, days_remaining, sample_count
  output logic [sgr_pkg::OUT_PAD-1:0]                 m_tdata,
  // sample_taken
  output logic                                        m_tuser,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [BYTE_BITS-1:0]                        cfg_data
);
  import sgr_pkg::*;

  sgr_cmd_t    ctl;
  sgr_status_t sts;

  assign cfg_ready = 1'b1;

  sgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  sgr_datapath #(
    .BYTE_BITS      (BYTE_BITS),
    .TIME_BITS      (TIME_BITS),
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // a request stays in work until its result is loaded; only then can the next be taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous still in work");

  a_taken_counts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[RATE_OUT_BITS+DAYS_BITS +: COUNT_BITS] != '0)
    else $error("sample taken with zero sample count");

  a_days_unknown: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[RATE_OUT_BITS+DAYS_BITS +: COUNT_BITS] < COUNT_BITS'(MIN_SAMPLES))
    |-> m_tdata[RATE_OUT_BITS +: DAYS_BITS] == '1)
    else $error("days estimate given with too few samples");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> sts.out_free)
    else $error("result register overwritten before it was read");

endmodule

// File: test/growth_estimate_checker.sv
// Checker for the growth rate estimator: watches the streams, predicts every result, compares.
`timescale 1ns / 1ps
module growth_estimate_checker #(
  parameter int BYTE_BITS      = 44,
  parameter int TIME_BITS      = 48,
  parameter int RATE_FRAC_BITS = 8
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  input  logic                                       s_tready,
  // usage, time in ms, reclaimed, free space
  input  logic [((3*BYTE_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
  // cmd
  input  logic                                       s_tuser,
  input  logic                                       m_tvalid,
  input  logic                                       m_tready,
  // rate_per_day, days_remaining, sample_count
  input  logic [sgr_pkg::OUT_PAD-1:0]                m_tdata,
  // sample_taken
  input  logic                                       m_tuser,
  input  logic                                       cfg_valid,
  input  logic                                       cfg_ready,
  input  logic [BYTE_BITS-1:0]                       cfg_data,
  output int                                         errors,
  output int                                         outstanding,
  output int                                         samples_seen
);

  localparam int BW      = BYTE_BITS;
  localparam int TW      = TIME_BITS;
  localparam int RATE_W  = 56;
  localparam int OUT_W   = 48;
  localparam int DAYS_W  = 54;
  localparam int COUNT_W = 8;
  localparam logic [63:0] MS_PER_DAY  = 64'd86400000;
  localparam int          MIN_GAP_MS  = 1000;
  localparam int          MIN_SAMPLES = 2;
  localparam logic [RATE_W-1:0]  RATE_CAP     = '1;
  localparam logic [COUNT_W-1:0] COUNT_CAP    = '1;
  localparam logic [DAYS_W-1:0]  DAYS_CAP     = {1'b0, {(DAYS_W-1){1'b1}}};
  localparam logic [DAYS_W-1:0]  DAYS_UNKNOWN = '1;
  localparam logic [RATE_W:0]    HALF_LSB     = (RATE_W+1)'((2**RATE_FRAC_BITS) / 2);

  typedef struct packed {
    logic [OUT_W-1:0]   rate;
    logic [DAYS_W-1:0]  days;
    logic [COUNT_W-1:0] count;
    logic               taken;
  } growth_report_t;

  growth_report_t expected_reports[$];

  logic [BW-1:0]      prev_used;
  logic [TW-1:0]      prev_time;
  logic [BW-1:0]      owed_cleanup;
  logic [RATE_W-1:0]  rate_q;
  logic [COUNT_W-1:0] sample_count;
  logic [BW-1:0]      reserve;

  // Advances the estimator state by one request and returns the report it should give.
  function automatic growth_report_t predict_report(input logic is_cleanup,
                                                    input logic [BW-1:0] used,
                                                    input logic [TW-1:0] tnow,
                                                    input logic [BW-1:0] recl,
                                                    input logic [BW-1:0] freeb);
    growth_report_t r;
    logic [BW:0]       owed_sum;
    logic [TW-1:0]     elapsed;
    logic [BW-1:0]     base;
    logic [127:0]      scaled;
    logic [127:0]      quotient;
    logic [RATE_W-1:0] sample;
    logic [63:0]       blended;
    logic [RATE_W:0]   rounded;
    r = '0;
    if (is_cleanup) begin
      owed_sum = {1'b0, owed_cleanup} + {1'b0, recl};
      owed_cleanup = owed_sum[BW] ? '1 : owed_sum[BW-1:0];
    end else begin
      if (prev_time != '0 && tnow > prev_time) begin
        elapsed = tnow - prev_time;
        base = (prev_used > owed_cleanup) ? prev_used - owed_cleanup : '0;
        if (used >= base && elapsed >= TW'(MIN_GAP_MS)) begin
          scaled   = (128'(used - base) * 128'(MS_PER_DAY)) << RATE_FRAC_BITS;
          quotient = scaled / 128'(elapsed);
          sample   = (quotient > 128'(RATE_CAP)) ? RATE_CAP : quotient[RATE_W-1:0];
          if (sample_count == '0) begin
            rate_q = sample;
          end else begin
            // 0.8 old + 0.2 new, truncated
            blended = (64'(rate_q) << 2) + 64'(sample);
            rate_q  = RATE_W'(blended / 64'd5);
          end
          if (sample_count != COUNT_CAP) sample_count = sample_count + 1'b1;
          r.taken = 1'b1;
        end
      end
      prev_used    = used;
      prev_time    = tnow;
      owed_cleanup = '0;
    end

    rounded = ({1'b0, rate_q} + HALF_LSB) >> RATE_FRAC_BITS;
    r.rate  = (rounded > (RATE_W+1)'({OUT_W{1'b1}})) ? '1 : rounded[OUT_W-1:0];

    if (sample_count < COUNT_W'(MIN_SAMPLES) || rate_q == '0) begin
      r.days = DAYS_UNKNOWN;
    end else if (freeb <= reserve) begin
      r.days = '0;
    end else begin
      quotient = (128'(freeb - reserve) << RATE_FRAC_BITS) / 128'(rate_q);
      r.days   = (quotient > 128'(DAYS_CAP)) ? DAYS_CAP : quotient[DAYS_W-1:0];
    end
    r.count = sample_count;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    growth_report_t want;
    if (rst) begin
      prev_used    = '0;
      prev_time    = '0;
      owed_cleanup = '0;
      rate_q       = '0;
      sample_count = '0;
      reserve      = '0;
      errors       = 0;
      samples_seen = 0;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) reserve = cfg_data;
      if (s_tvalid && s_tready) begin
        want = predict_report(s_tuser, s_tdata[BW-1:0], s_tdata[BW+TW-1:BW],
                              s_tdata[2*BW+TW-1:BW+TW], s_tdata[3*BW+TW-1:2*BW+TW]);
        if (want.taken) samples_seen++;
        expected_reports.insert(expected_reports.size(), want);
      end
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding, expected none, got %0h/%0b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = expected_reports.pop_front();
          check_field("rate_per_day", 64'(want.rate), 64'(m_tdata[OUT_W-1:0]));
          check_field("days_remaining", 64'(want.days), 64'(m_tdata[OUT_W+DAYS_W-1:OUT_W]));
          check_field("sample_count", 64'(want.count),
                      64'(m_tdata[OUT_W+DAYS_W+COUNT_W-1:OUT_W+DAYS_W]));
          check_field("sample_taken", 64'(want.taken), 64'(m_tuser));
        end
      end
    end
    outstanding = expected_reports.size();
  end

endmodule

// File: test/tb_storage_growth_rate_estimator.sv
// Testbench top for the storage growth rate estimator: stimulus, idling, reserve writes, verdict.
`timescale 1ns / 1ps
module tb_storage_growth_rate_estimator;

  localparam int BW = 44;
  localparam int TW = 48;
  localparam int IN_PAD = ((3*BW+TW+7)/8)*8;
  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_CLEANUP = 1'b1;
  localparam logic [BW-1:0] BYTES_MAX = '1;
  localparam logic [TW-1:0] TIME_MAX  = '1;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 104;
  localparam int DRAIN_CYCLES = 300;

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [IN_PAD-1:0]           s_tdata;
  logic                        s_tuser;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [sgr_pkg::OUT_PAD-1:0] m_tdata;
  logic                        m_tuser;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [BW-1:0]               cfg_data;

  int errors;
  int outstanding;
  int samples_seen;

  int gap_odds;
  int stall_odds;
  int stall_left;
  int n_observe;
  int n_cleanup;
  int n_reserve;
  logic [BW-1:0] reserve_now;
  logic [BW-1:0] last_used;
  logic [BW-1:0] owed;
  logic [TW-1:0] last_time;

  storage_growth_rate_estimator DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  growth_estimate_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding),
    .samples_seen (samples_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side back-pressure, in bursts
  initial begin
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        m_tready   = 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // random value of a random magnitude, up to n bits
  function automatic logic [63:0] scaled(input int n);
    int k;
    k = $urandom_range(0, n);
    return (k == 0) ? 64'd0 : rnd64() >> (64 - k);
  endfunction

  function automatic logic [BW-1:0] any_bytes();
    return BW'(rnd64());
  endfunction

  function automatic logic [TW-1:0] any_time();
    return TW'(rnd64());
  endfunction

  // free space around the reserve edge as well as anywhere
  function automatic logic [BW-1:0] pick_free();
    case ($urandom_range(0, 7))
      0: return reserve_now;
      1: return (reserve_now == BYTES_MAX) ? reserve_now : reserve_now + 1'b1;
      2: return '0;
      3: return BYTES_MAX;
      default: return BW'(scaled(BW));
    endcase
  endfunction

  function automatic logic [TW-1:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0: return TW'(1000);
      1: return TW'($urandom_range(0, 999));
      2: return TW'(scaled(40));
      default: return TW'($urandom_range(1000, 120000));
    endcase
  endfunction

  task automatic send_request(input logic cmd, input logic [BW-1:0] used,
                              input logic [TW-1:0] tms, input logic [BW-1:0] recl,
                              input logic [BW-1:0] freeb);
    int gap;
    logic [BW:0] owed_sum;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      gap = $urandom_range(1, 17);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {freeb, recl, tms, used};
    s_tuser  = cmd;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (cmd == CMD_OBSERVE) begin
      n_observe++;
      last_used = used;
      last_time = tms;
      owed      = '0;
    end else begin
      n_cleanup++;
      owed_sum = {1'b0, owed} + {1'b0, recl};
      owed     = owed_sum[BW] ? BYTES_MAX : owed_sum[BW-1:0];
    end
  endtask

  task automatic write_reserve(input logic [BW-1:0] value);
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid   = 1'b0;
    reserve_now = value;
    n_reserve++;
  endtask

  // hold off new requests until every result is back
  task automatic settle();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_request();
    int kind;
    logic [TW:0]   t_next;
    logic [BW:0]   u_next;
    logic [BW-1:0] base;
    logic [BW-1:0] growth;
    logic [BW-1:0] recl;
    logic [BW-1:0] freeb;
    kind  = $urandom_range(0, 99);
    freeb = pick_free();
    if (kind < 70) begin
      // well-formed observation: time moves on, usage grows from the credited base
      t_next = {1'b0, last_time} + {1'b0, pick_elapsed()};
      if (last_time == '0 || t_next > {1'b0, TIME_MAX}) t_next = (TW+1)'($urandom_range(1, 5000));
      base   = (last_used > owed) ? last_used - owed : '0;
      growth = ($urandom_range(0, 9) == 0) ? '0 : BW'(scaled(BW));
      u_next = {1'b0, base} + {1'b0, growth};
      send_request(CMD_OBSERVE, u_next[BW] ? any_bytes() : u_next[BW-1:0],
                   t_next[TW-1:0], any_bytes(), freeb);
    end else if (kind < 88) begin
      recl = ($urandom_range(0, 4) == 0) ? BW'(scaled(BW)) : last_used >> $urandom_range(0, 20);
      send_request(CMD_CLEANUP, any_bytes(), any_time(), recl, freeb);
    end else begin
      send_request(CMD_OBSERVE, any_bytes(), ($urandom_range(0, 3) == 0) ? '0 : any_time(),
                   any_bytes(), freeb);
    end
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = CMD_OBSERVE;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    gap_odds    = 3;
    stall_odds  = 3;
    n_observe   = 0;
    n_cleanup   = 0;
    n_reserve   = 0;
    reserve_now = '0;
    last_used   = '0;
    last_time   = '0;
    owed        = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    write_reserve('0);

    // no earlier time yet, and zero time
    send_request(CMD_OBSERVE, '0, '0, any_bytes(), BYTES_MAX);
    send_request(CMD_OBSERVE, 44'd1000, '0, any_bytes(), any_bytes());
    send_request(CMD_OBSERVE, 44'd1000, 48'd1, any_bytes(), '0);
    // just under a second
    send_request(CMD_OBSERVE, 44'd2000, 48'd1000, any_bytes(), any_bytes());
    // cleanup sum runs into its ceiling
    send_request(CMD_CLEANUP, any_bytes(), any_time(), BYTES_MAX, any_bytes());
    send_request(CMD_CLEANUP, any_bytes(), any_time(), BYTES_MAX, BYTES_MAX);
    // flat usage: zero first sample, then a second, so two samples with a zero rate
    send_request(CMD_OBSERVE, '0, 48'd2000, any_bytes(), BYTES_MAX);
    send_request(CMD_OBSERVE, '0, 48'd3000, any_bytes(), BYTES_MAX);
    // full swing in one second saturates the sample
    send_request(CMD_OBSERVE, BYTES_MAX, 48'd4000, any_bytes(), BYTES_MAX);
    // usage drops with no cleanup to explain it
    send_request(CMD_OBSERVE, BYTES_MAX - 1'b1, 48'd5000, any_bytes(), 44'd1);
    send_request(CMD_CLEANUP, any_bytes(), any_time(), 44'd5, '0);
    // usage lands exactly on the credited base
    send_request(CMD_OBSERVE, BYTES_MAX - 44'd6, 48'd6000, any_bytes(), BYTES_MAX);
    // time runs backwards
    send_request(CMD_OBSERVE, BYTES_MAX - 44'd100, 48'd5500, any_bytes(), BYTES_MAX);
    send_request(CMD_OBSERVE, BYTES_MAX, TIME_MAX, any_bytes(), 44'd12345);
    send_request(CMD_OBSERVE, BYTES_MAX, TIME_MAX, any_bytes(), BYTES_MAX);
    send_request(CMD_OBSERVE, '0, 48'd1, any_bytes(), any_bytes());
    send_request(CMD_OBSERVE, 44'd1, 48'd1001, any_bytes(), BYTES_MAX);
    send_request(CMD_CLEANUP, any_bytes(), any_time(), '0, 44'd1);
    send_request(CMD_OBSERVE, 44'd4096, 48'd90000, any_bytes(), pick_free());

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin write_reserve(BYTES_MAX);         gap_odds = 4; stall_odds = 4; end
        1: begin write_reserve(any_bytes());       gap_odds = 0; stall_odds = 3; end
        2: begin write_reserve(BW'(scaled(20)));   gap_odds = 2; stall_odds = 0; end
        3: begin write_reserve('0);                gap_odds = 8; stall_odds = 8; end
        default: begin write_reserve(any_bytes()); gap_odds = 0; stall_odds = 0; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) random_request();
    end

    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d observations and %0d cleanups under %0d reserve settings,",
             n_observe, n_cleanup, n_reserve);
    $display("with %0d growth samples folded into the rate.", samples_seen);
    if (errors == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
